FILE: rtl/icmn_pkg.sv
// Shared types and constants for the image crop, mirror and normalize block.
// Used by icmn_crop and image_crop_mirror_normalize; depends on nothing.
package icmn_pkg;

  localparam int MAX_DIM_DEF      = 1024;
  localparam int MAX_CHANNELS_DEF = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int ADDR_W     = 22;
  localparam int MEAN_W     = 12;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CROP_SIZE  = 3'd0,
    REG_IMG_HEIGHT = 3'd1,
    REG_IMG_WIDTH  = 3'd2,
    REG_CHANNELS   = 3'd3,
    REG_CH_MEANS   = 3'd4,
    REG_SCALE      = 3'd5,
    REG_MODE       = 3'd6
  } cfg_reg_e;

  // Mean select codes, mode bits 1:0.
  typedef enum logic [1:0] {
    MEAN_NONE  = 2'd0,
    MEAN_CHAN  = 2'd1,
    MEAN_PIXEL = 2'd2
  } mean_sel_e;

  localparam logic [10:0] CROP_SIZE_RST  = 11'd0;
  localparam logic [10:0] IMG_HEIGHT_RST = 11'd256;
  localparam logic [10:0] IMG_WIDTH_RST  = 11'd256;
  localparam logic [2:0]  CHANNELS_RST   = 3'd3;
  localparam logic [47:0] CH_MEANS_RST   = 48'd0;
  localparam logic [23:0] SCALE_RST      = 24'd65536;
  localparam logic [3:0]  MODE_RST       = 4'd0;

  localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [7:0]  pixel;
    logic [11:0] pixel_mean;
    logic        first;
    logic [9:0]  rand_row_off;
    logic [9:0]  rand_col_off;
    logic        rand_mirror;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  out_addr;
    logic signed [31:0] out_value;
    logic               last;
  } out_word_t;

  // Window decision for the byte being accepted.
  typedef struct packed {
    logic keep;
    logic last;
  } crop_flags_t;

endpackage

FILE: rtl/icmn_crop.sv
// Position tracking for the crop window: row, column and channel counters,
// latched crop origin and mirror flag. Depends on icmn_pkg.
module icmn_crop
  import icmn_pkg::*;
#(
  parameter int MAX_DIM      = MAX_DIM_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  in_word_t                word,
  input  logic [$clog2(MAX_DIM+1)-1:0]      eff_h,
  input  logic [$clog2(MAX_DIM+1)-1:0]      eff_w,
  input  logic [$clog2(MAX_CHANNELS+1)-1:0] eff_c,
  input  logic [$clog2(MAX_DIM+1)-1:0]      crop_h,
  input  logic [$clog2(MAX_DIM+1)-1:0]      crop_w,
  input  logic                    train,
  input  logic                    mirror_en,
  output crop_flags_t             flags,
  output logic [$clog2(MAX_DIM)-1:0] h,
  output logic [$clog2(MAX_DIM)-1:0] wo,
  output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] k
);

  localparam int DW   = $clog2(MAX_DIM+1);
  localparam int OW   = $clog2(MAX_DIM);
  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [OW-1:0]   row_count, col_count;
  logic [CH_W-1:0] chan_count;
  logic [OW-1:0]   row_offset, col_offset;
  logic            mirror_on;

  logic [DW-1:0]   slack_h, slack_w;
  logic [OW-1:0]   new_row_off, new_col_off;
  logic [OW-1:0]   r, c, off_r, off_c, w;
  logic            mir;
  logic            in_row, in_col, in_chan;
  logic [CH_W:0]   k_inc;
  logic [OW:0]     c_inc, r_inc;
  logic [OW-1:0]   row_count_next, col_count_next;
  logic [CH_W-1:0] chan_count_next;

  assign slack_h = eff_h - crop_h;
  assign slack_w = eff_w - crop_w;

  // Test phase centers the window; train phase takes the offered offset,
  // held to the available slack.
  always_comb begin
    if (train) begin
      new_row_off = (32'(word.rand_row_off) > 32'(slack_h)) ? OW'(slack_h)
                                                             : OW'(word.rand_row_off);
      new_col_off = (32'(word.rand_col_off) > 32'(slack_w)) ? OW'(slack_w)
                                                             : OW'(word.rand_col_off);
    end else begin
      new_row_off = OW'(slack_h >> 1);
      new_col_off = OW'(slack_w >> 1);
    end
  end

  assign r     = word.first ? '0 : row_count;
  assign c     = word.first ? '0 : col_count;
  assign k     = word.first ? '0 : chan_count;
  assign off_r = word.first ? new_row_off : row_offset;
  assign off_c = word.first ? new_col_off : col_offset;
  assign mir   = word.first ? (mirror_en & word.rand_mirror) : mirror_on;

  assign h = r - off_r;
  assign w = c - off_c;

  assign in_row  = (r >= off_r) && (32'(h) < 32'(crop_h));
  assign in_col  = (c >= off_c) && (32'(w) < 32'(crop_w));
  assign in_chan = 32'(k) < 32'(eff_c);

  assign wo = mir ? OW'(crop_w - DW'(1) - DW'(w)) : w;

  assign flags.keep = in_row && in_col && in_chan;
  assign flags.last = (DW'(h) == crop_h - DW'(1)) && (DW'(w) == crop_w - DW'(1)) &&
                      (32'(k) == 32'(eff_c) - 32'd1);

  // Counters step through HWC order and wrap past the image's last byte.
  always_comb begin
    k_inc           = (CH_W+1)'(k) + 1'b1;
    c_inc           = (OW+1)'(c) + 1'b1;
    r_inc           = (OW+1)'(r) + 1'b1;
    chan_count_next = k_inc[CH_W-1:0];
    col_count_next  = c;
    row_count_next  = r;
    if (32'(k_inc) >= 32'(eff_c)) begin
      chan_count_next = '0;
      col_count_next  = c_inc[OW-1:0];
      if (32'(c_inc) >= 32'(eff_w)) begin
        col_count_next = '0;
        row_count_next = r_inc[OW-1:0];
        if (32'(r_inc) >= 32'(eff_h)) begin
          row_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= '0;
      col_count  <= '0;
      chan_count <= '0;
      row_offset <= '0;
      col_offset <= '0;
      mirror_on  <= 1'b0;
    end else if (accept) begin
      row_count  <= row_count_next;
      col_count  <= col_count_next;
      chan_count <= chan_count_next;
      if (word.first) begin
        row_offset <= new_row_off;
        col_offset <= new_col_off;
        mirror_on  <= mirror_en & word.rand_mirror;
      end
    end
  end

endmodule

FILE: rtl/image_crop_mirror_normalize.sv
// Image crop, mirror and mean-subtract with HWC to CHW addressing.
// Path: a kept byte's word passes the stage 1, stage 2 and output registers before it is
// shown on res_valid.
// Throughput: one source byte per cycle; the three-stage pipeline (window and mean
// subtract, address and scale multipliers, final address and saturation) collapses
// bubbles, and src_stall rises only when all three stages hold a word and the last is stalled.
// Reset (rst, synchronous) restores the register defaults and clears counters.
module image_crop_mirror_normalize
  import icmn_pkg::*;
#(
  parameter int MAX_DIM      = MAX_DIM_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  src_valid,
  output logic                  src_stall,
  input  in_word_t              src_word,
  output logic                  res_valid,
  input  logic                  res_stall,
  output out_word_t             res_word
);

  localparam int DW   = $clog2(MAX_DIM+1);
  localparam int OW   = $clog2(MAX_DIM);
  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW   = $clog2(MAX_CHANNELS+1);
  localparam int BW   = CH_W + DW + 1;
  localparam int AP_W = (BW + DW + 1 > ADDR_W) ? BW + DW + 1 : ADDR_W;

  // Configuration registers.
  logic [10:0] crop_edge, src_rows, src_cols;
  logic [2:0]  channels;
  logic [47:0] channel_means;
  logic [23:0] scale;
  logic [3:0]  mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      crop_edge     <= CROP_SIZE_RST;
      src_rows      <= IMG_HEIGHT_RST;
      src_cols      <= IMG_WIDTH_RST;
      channels      <= CHANNELS_RST;
      channel_means <= CH_MEANS_RST;
      scale         <= SCALE_RST;
      mode          <= MODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CROP_SIZE:  crop_edge     <= cfg_data[10:0];
        REG_IMG_HEIGHT: src_rows      <= cfg_data[10:0];
        REG_IMG_WIDTH:  src_cols      <= cfg_data[10:0];
        REG_CHANNELS:   channels      <= cfg_data[2:0];
        REG_CH_MEANS:   channel_means <= cfg_data[47:0];
        REG_SCALE:      scale         <= cfg_data[23:0];
        REG_MODE:       mode          <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Effective geometry from the registers.
  logic [DW-1:0] eff_h, eff_w, crop_h, crop_w;
  logic [CW-1:0] eff_c;

  always_comb begin
    if (src_rows == '0) begin
      eff_h = DW'(1);
    end else if (32'(src_rows) > 32'(MAX_DIM)) begin
      eff_h = DW'(MAX_DIM);
    end else begin
      eff_h = DW'(src_rows);
    end
    if (src_cols == '0) begin
      eff_w = DW'(1);
    end else if (32'(src_cols) > 32'(MAX_DIM)) begin
      eff_w = DW'(MAX_DIM);
    end else begin
      eff_w = DW'(src_cols);
    end
    if (channels == '0) begin
      eff_c = CW'(1);
    end else if (32'(channels) > 32'(MAX_CHANNELS)) begin
      eff_c = CW'(MAX_CHANNELS);
    end else begin
      eff_c = CW'(channels);
    end
    // A zero crop or one larger than the image keeps the whole edge.
    crop_h = (crop_edge == '0 || 32'(crop_edge) > 32'(eff_h)) ? eff_h : DW'(crop_edge);
    crop_w = (crop_edge == '0 || 32'(crop_edge) > 32'(eff_w)) ? eff_w : DW'(crop_edge);
  end

  // Pipeline flow control: each stage moves when it is empty or its successor moves.
  logic v1, v2, v3;
  logic adv1, adv2, adv3;
  logic accept;

  assign adv3      = !v3 || !res_stall;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign src_stall = !adv1;
  assign accept    = src_valid && adv1;

  // Stage 0: window position and mean subtraction.
  crop_flags_t     flags;
  logic [OW-1:0]   pos_h, pos_wo;
  logic [CH_W-1:0] pos_k;
  logic [1:0]      mean_idx;
  logic [MEAN_W-1:0] mean;
  logic signed [12:0] diff;

  icmn_crop #(
    .MAX_DIM      (MAX_DIM),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_crop (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .word      (src_word),
    .eff_h     (eff_h),
    .eff_w     (eff_w),
    .eff_c     (eff_c),
    .crop_h    (crop_h),
    .crop_w    (crop_w),
    .train     (mode[2]),
    .mirror_en (mode[3]),
    .flags     (flags),
    .h         (pos_h),
    .wo        (pos_wo),
    .k         (pos_k)
  );

  assign mean_idx = 2'(pos_k);

  always_comb begin
    unique case (mode[1:0])
      MEAN_CHAN:  mean = channel_means[mean_idx*MEAN_W +: MEAN_W];
      MEAN_PIXEL: mean = src_word.pixel_mean;
      default:    mean = '0;
    endcase
  end

  assign diff = $signed({1'b0, src_word.pixel, 4'b0000}) - $signed({1'b0, mean});

  // Stage 1 registers.
  logic [OW-1:0]      h1, wo1;
  logic [CH_W-1:0]    k1;
  logic               last1;
  logic signed [12:0] diff1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= accept && flags.keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      h1    <= pos_h;
      wo1   <= pos_wo;
      k1    <= pos_k;
      last1 <= flags.last;
      diff1 <= diff;
    end
  end

  // Stage 2: channel plane base and the scale product.
  logic [BW-1:0]      base2;
  logic [OW-1:0]      wo2;
  logic               last2;
  logic signed [37:0] prod2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      base2 <= BW'(BW'(k1) * BW'(crop_h)) + BW'(h1);
      wo2   <= wo1;
      last2 <= last1;
      prod2 <= 38'(diff1) * $signed({14'd0, scale});
    end
  end

  // Stage 3: row address, floor shift to Q15.16 and saturation.
  logic [AP_W-1:0]    addr_full;
  logic signed [37:0] shifted;
  logic signed [31:0] value;

  assign addr_full = AP_W'(base2) * AP_W'(crop_w) + AP_W'(wo2);
  assign shifted   = prod2 >>> 4;

  always_comb begin
    if (shifted > 38'(VALUE_MAX)) begin
      value = VALUE_MAX;
    end else if (shifted < 38'(VALUE_MIN)) begin
      value = VALUE_MIN;
    end else begin
      value = shifted[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      res_word.out_addr  <= addr_full[ADDR_W-1:0];
      res_word.out_value <= value;
      res_word.last      <= last2;
    end
  end

  assign res_valid = v3;

endmodule

FILE: tb/tb_image_crop_mirror_normalize.sv
`timescale 1ns / 100ps
// Self-checking testbench for image_crop_mirror_normalize: streams source bytes,
// predicts each kept byte's CHW word and compares it. Needs icmn_pkg and the RTL.
module tb_image_crop_mirror_normalize;
  import icmn_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 200;
  localparam int WATCHDOG_MAX = 5000;
  localparam int RANDOM_WORDS = 1120;
  localparam int MAX_REPORTS  = 10;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  src_valid;
  logic                  src_stall;
  in_word_t              src_word;
  logic                  res_valid;
  logic                  res_stall;
  out_word_t             res_word;

  // Shadow copy of the register file.
  logic [10:0] crop_reg   = CROP_SIZE_RST;
  logic [10:0] height_reg = IMG_HEIGHT_RST;
  logic [10:0] width_reg  = IMG_WIDTH_RST;
  logic [2:0]  chan_reg   = CHANNELS_RST;
  logic [47:0] means_reg  = CH_MEANS_RST;
  logic [23:0] scale_reg  = SCALE_RST;
  logic [3:0]  mode_reg   = MODE_RST;

  // Position of the next source byte and the latched crop origin.
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;
  int unsigned chan_pos = 0;
  int unsigned row_org = 0;
  int unsigned col_org = 0;
  bit          mirror_latched = 1'b0;

  out_word_t   expected_words[$];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned settings_used = 1;
  int unsigned stuck_cycles = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;

  image_crop_mirror_normalize i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_word  (src_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic int unsigned window_len(int unsigned dim);
    return (crop_reg == 0 || crop_reg > dim) ? dim : int'(crop_reg);
  endfunction

  function automatic int unsigned origin_of(int unsigned dim, int unsigned rnd);
    int unsigned slack;
    slack = dim - window_len(dim);
    if (mode_reg[2]) return (rnd > slack) ? slack : rnd;
    return slack / 2;
  endfunction

  function automatic in_word_t make_word(logic [7:0] pix, logic [11:0] pmean, logic first,
                                         logic [9:0] roff, logic [9:0] coff, logic mir);
    in_word_t w;
    w.pixel        = pix;
    w.pixel_mean   = pmean;
    w.first        = first;
    w.rand_row_off = roff;
    w.rand_col_off = coff;
    w.rand_mirror  = mir;
    return w;
  endfunction

  // Advances the byte counters and queues the CHW word that a kept byte gives.
  task automatic predict_crop(input in_word_t w);
    int unsigned hgt, wid, nch, win_h, win_w, h, c, wo;
    longint      diff, prod, q;
    logic [11:0] mean;
    out_word_t   o;
    hgt   = clamp_dim(height_reg, MAX_DIM_DEF);
    wid   = clamp_dim(width_reg, MAX_DIM_DEF);
    nch   = clamp_dim(chan_reg, MAX_CHANNELS_DEF);
    win_h = window_len(hgt);
    win_w = window_len(wid);
    if (w.first) begin
      row_pos = 0;
      col_pos = 0;
      chan_pos = 0;
      row_org = origin_of(hgt, w.rand_row_off);
      col_org = origin_of(wid, w.rand_col_off);
      mirror_latched = mode_reg[3] & w.rand_mirror;
    end
    if (row_pos >= row_org && row_pos - row_org < win_h &&
        col_pos >= col_org && col_pos - col_org < win_w && chan_pos < nch) begin
      h  = row_pos - row_org;
      c  = col_pos - col_org;
      wo = mirror_latched ? win_w - 1 - c : c;
      case (mean_sel_e'(mode_reg[1:0]))
        MEAN_CHAN:  mean = means_reg[12*chan_pos +: 12];
        MEAN_PIXEL: mean = w.pixel_mean;
        default:    mean = '0;
      endcase
      diff = longint'({w.pixel, 4'b0000}) - longint'(mean);
      prod = diff * longint'(scale_reg);
      // Arithmetic shift truncates toward minus infinity.
      q = prod >>> 4;
      if (q > VALUE_MAX) q = VALUE_MAX;
      if (q < VALUE_MIN) q = VALUE_MIN;
      o.out_addr  = ADDR_W'((chan_pos * win_h + h) * win_w + wo);
      o.out_value = q[31:0];
      o.last      = (h == win_h - 1) && (c == win_w - 1) && (chan_pos == nch - 1);
      expected_words.insert(expected_words.size(), o);
    end
    chan_pos++;
    if (chan_pos >= nch) begin
      chan_pos = 0;
      col_pos++;
      if (col_pos >= wid) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= hgt) row_pos = 0;
      end
    end
  endtask

  // Called and returns at a falling edge; valid stays high for a following word.
  task automatic send_word(input in_word_t w);
    while (idle_on && $urandom_range(99) < 6) begin
      src_valid <= 1'b0;
      @(negedge clk);
    end
    src_valid <= 1'b1;
    src_word  <= w;
    do @(posedge clk); while (src_stall);
    predict_crop(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    src_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    // A byte outside the window leaves no word behind and is not marked valid in stage 1.
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic [10:0] crop, input logic [10:0] hgt,
                            input logic [10:0] wid, input logic [2:0] chans,
                            input logic [47:0] means, input logic [23:0] scl,
                            input logic [3:0] md);
    cfg_reg_e r;
    drain_pipe();
    r = r.first();
    repeat (r.num()) begin
      cfg_we    <= 1'b1;
      cfg_index <= r;
      case (r)
        REG_CROP_SIZE:  begin cfg_data <= CFG_DATA_W'(crop);  crop_reg   = crop;  end
        REG_IMG_HEIGHT: begin cfg_data <= CFG_DATA_W'(hgt);   height_reg = hgt;   end
        REG_IMG_WIDTH:  begin cfg_data <= CFG_DATA_W'(wid);   width_reg  = wid;   end
        REG_CHANNELS:   begin cfg_data <= CFG_DATA_W'(chans); chan_reg   = chans; end
        REG_CH_MEANS:   begin cfg_data <= CFG_DATA_W'(means); means_reg  = means; end
        REG_SCALE:      begin cfg_data <= CFG_DATA_W'(scl);   scale_reg  = scl;   end
        default:        begin cfg_data <= CFG_DATA_W'(md);    mode_reg   = md;    end
      endcase
      @(negedge clk);
      r = r.next();
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Sends one image of the current geometry, mostly well formed; some images lack
  // the start mark and some are cut short.
  task automatic send_image(input int unsigned cap);
    int unsigned hgt, wid, total, kind, slack_h, slack_w;
    in_word_t    w;
    hgt     = clamp_dim(height_reg, MAX_DIM_DEF);
    wid     = clamp_dim(width_reg, MAX_DIM_DEF);
    total   = hgt * wid * clamp_dim(chan_reg, MAX_CHANNELS_DEF);
    slack_h = hgt - window_len(hgt);
    slack_w = wid - window_len(wid);
    kind    = $urandom_range(99);
    if (kind >= 90) total = $urandom_range(1, total);
    if (total > cap) total = cap;
    for (int unsigned n = 0; n < total; n++) begin
      w.pixel = 8'($urandom);
      if ($urandom_range(7) == 0) w.pixel = $urandom_range(1) ? 8'hFF : 8'h00;
      w.pixel_mean = 12'($urandom);
      if ($urandom_range(7) == 0) w.pixel_mean = $urandom_range(1) ? 12'hFFF : 12'h000;
      w.first = (n == 0) && (kind < 80 || kind >= 90);
      if ($urandom_range(1)) begin
        w.rand_row_off = 10'($urandom_range(0, slack_h));
        w.rand_col_off = 10'($urandom_range(0, slack_w));
      end else begin
        w.rand_row_off = 10'($urandom);
        w.rand_col_off = 10'($urandom);
      end
      w.rand_mirror = 1'($urandom_range(1));
      send_word(w);
    end
  endtask

  task automatic random_config();
    logic [10:0] crop, hgt, wid;
    logic [23:0] scl;
    hgt = 11'($urandom_range(1, 8));
    if ($urandom_range(15) == 0) hgt = '0;
    wid = 11'($urandom_range(1, 8));
    if ($urandom_range(15) == 0) wid = '0;
    case ($urandom_range(3))
      0:       crop = '0;
      1:       crop = 11'($urandom_range(1, 4));
      2:       crop = 11'($urandom_range(1, 10));
      default: crop = 11'($urandom_range(0, 1024));
    endcase
    case ($urandom_range(4))
      0:       scl = 24'hFFFFFF;
      1:       scl = 24'h010000;
      2:       scl = '0;
      default: scl = 24'($urandom);
    endcase
    set_config(crop, hgt, wid, 3'($urandom_range(0, 7)), {16'($urandom), 32'($urandom)},
               scl, 4'($urandom_range(0, 15)));
  endtask

  task automatic test_reset_defaults();
    send_word(make_word(8'h00, 12'h000, 1'b1, 10'h3FF, 10'h3FF, 1'b1));
    send_word(make_word(8'hFF, 12'hFFF, 1'b0, 10'h000, 10'h000, 1'b0));
    send_word(make_word(8'h80, 12'h800, 1'b0, 10'h155, 10'h2AA, 1'b1));
  endtask

  // Oversized offsets saturate to the slack; extremes saturate the value both ways.
  task automatic test_train_mirror();
    set_config(11'd2, 11'd3, 11'd3, 3'd1, 48'd0, 24'hFFFFFF, 4'({2'b11, MEAN_PIXEL}));
    for (int i = 0; i < 9; i++)
      send_word(make_word(i[0] ? 8'h00 : 8'hFF, i[0] ? 12'hFFF : 12'h000, i == 0,
                          10'h3FF, 10'h3FF, 1'b1));
  endtask

  // Zero height, too many channels and a crop wider than the image all clamp.
  task automatic test_clamps();
    set_config(11'd5, 11'd0, 11'd2, 3'd7, {12'hFFF, 12'h800, 12'h001, 12'h000},
               24'h010000, 4'({2'b00, MEAN_CHAN}));
    for (int i = 0; i < 8; i++)
      send_word(make_word(8'(i * 37), 12'h000, i == 0, 10'h000, 10'h000, 1'b0));
  endtask

  task automatic test_extremes();
    set_config(11'd1024, 11'd1024, 11'd1024, 3'd4, 48'hFFFF_FFFF_FFFF, 24'hFFFFFF, 4'hF);
    send_image(80);
    set_config(11'd0, 11'd1, 11'd1, 3'd1, 48'd0, 24'd0, 4'({2'b00, MEAN_NONE}));
    repeat (20) send_image(1);
  endtask

  // The output side holds off while the input keeps offering bytes.
  task automatic test_backpressure();
    set_config(11'd0, 11'd8, 11'd8, 3'd1, 48'd0, 24'h010000, 4'({2'b00, MEAN_NONE}));
    hold_req = 1'b1;
    for (int i = 0; i < 64; i++)
      send_word(make_word(8'($urandom), 12'($urandom), i == 0, 10'h000, 10'h000, 1'b0));
  endtask

  task automatic test_random_images();
    int unsigned target, phase;
    target = words_sent + RANDOM_WORDS;
    phase  = 0;
    while (words_sent < target) begin
      random_config();
      idle_on = (phase != 2) && (phase != 3);
      repeat ($urandom_range(1, 3))
        send_image((target - words_sent > 256) ? 256 : target - words_sent);
      phase++;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      res_stall <= idle_on && ($urandom_range(99) < 6);
    end
  end

  always @(posedge clk) begin : check_words
    out_word_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected word: addr %0d value %0d last %0b",
                   res_word.out_addr, res_word.out_value, res_word.last);
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (res_word.out_addr !== want.out_addr || res_word.out_value !== want.out_value ||
            res_word.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Mismatch on word %0d: expected addr %0d value %0d last %0b, got %0d %0d %0b",
                     words_checked, want.out_addr, want.out_value, want.last,
                     res_word.out_addr, res_word.out_value, res_word.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (src_valid && !src_stall) || (res_valid && !res_stall) ||
        (!src_valid && expected_words.size() == 0)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_MAX) begin
        $display("Timeout: no word moved for %0d cycles, %0d words outstanding",
                 stuck_cycles, expected_words.size());
        $display("image_crop_mirror_normalize test failed");
        $finish;
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    src_valid = 1'b0;
    src_word  = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_train_mirror();
    test_clamps();
    test_extremes();
    test_backpressure();
    test_random_images();
    drain_pipe();
    mismatches += expected_words.size();
    $display("Sent %0d source words, checked %0d result words over %0d register settings,",
             words_sent, words_checked, settings_used);
    $display("covering crop, mirror, all mean modes, saturation, size clamps and a long hold.");
    if (mismatches == 0) begin
      $display("image_crop_mirror_normalize test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("image_crop_mirror_normalize test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/icmn_pkg.sv
rtl/icmn_crop.sv
rtl/image_crop_mirror_normalize.sv
tb/tb_image_crop_mirror_normalize.sv
